// ===== hw/rtl/i2cms_pkg.sv =====
// Shared types and codes of the I2C master transaction sequencer.
package i2cms_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_EVENT = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ACT_NONE    = 4'd0,
    ACT_START   = 4'd1,
    ACT_SEND    = 4'd2,
    ACT_ACK     = 4'd3,
    ACT_NACK    = 4'd4,
    ACT_STOP    = 4'd5,
    ACT_RELEASE = 4'd6,
    ACT_RSTART  = 4'd7,
    ACT_ADDR    = 4'd8
  } act_e;

  typedef enum logic [2:0] {
    RES_OK        = 3'd0,
    RES_NOT_READY = 3'd1,
    RES_BUS_ERR   = 3'd2,
    RES_ADDR_NACK = 3'd3,
    RES_DATA_NACK = 3'd4,
    RES_ARB_LOST  = 3'd5
  } res_e;

  typedef enum logic [2:0] {
    MODE_READY = 3'b001,
    MODE_READ  = 3'b010,
    MODE_WRITE = 3'b100
  } mode_e;

  // Bus status codes with the low three bits dropped.
  typedef enum logic [4:0] {
    ST_BUS_ERR    = 5'h00,
    ST_START      = 5'h01,
    ST_RSTART     = 5'h02,
    ST_WADDR_ACK  = 5'h03,
    ST_WADDR_NACK = 5'h04,
    ST_WDATA_ACK  = 5'h05,
    ST_WDATA_NACK = 5'h06,
    ST_ARB_LOST   = 5'h07,
    ST_RADDR_ACK  = 5'h08,
    ST_RADDR_NACK = 5'h09,
    ST_RDATA_ACK  = 5'h0A,
    ST_RDATA_NACK = 5'h0B
  } status_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] slave_address;
    logic [7:0] length;
    logic       send_stop;
    logic [4:0] load_index;
    logic [7:0] load_byte;
    logic [7:0] bus_status;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0] bus_action;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic [7:0] rx_index;
    logic       done_res;
    logic [2:0] result_code;
    logic       busy_res;
  } out_item_t;

  typedef struct packed {
    logic       en;
    logic [4:0] idx;
    logic [7:0] data;
  } buf_wr_t;

endpackage

// ===== hw/rtl/i2cms_buf.sv =====
// Transmit byte buffer with a registered read that tracks the next byte index.
module i2cms_buf #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic                clk_i,
  input  i2cms_pkg::buf_wr_t  wr_i,
  input  logic [7:0]          rd_idx_i,
  output logic [7:0]          rd_data_o
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [8:0] DEPTH9 = 9'(BUFFER_DEPTH);

  logic [7:0]    mem [BUFFER_DEPTH];
  logic [7:0]    rd_data_q;
  logic [8:0]    widx_ext;
  logic [8:0]    ridx_ext;
  logic          wr_ok;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  assign widx_ext = 9'(wr_i.idx);
  assign ridx_ext = 9'(rd_idx_i);
  assign wr_ok    = wr_i.en && (widx_ext < DEPTH9);
  assign waddr    = widx_ext[AW-1:0];
  // Out-of-range indexes are never sent; park the read on entry zero.
  assign raddr    = (ridx_ext < DEPTH9) ? ridx_ext[AW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[waddr] <= wr_i.data;
    end
  end

  // Forward a same-cycle load so the next transaction sees it.
  always_ff @(posedge clk_i) begin
    if (wr_ok && (waddr == raddr)) begin
      rd_data_q <= wr_i.data;
    end else begin
      rd_data_q <= mem[raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/i2cms_ctrl.sv =====
// Sequencer state and the per-transaction decision logic.
module i2cms_ctrl #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  i2cms_pkg::in_item_t   item_i,
  input  logic [7:0]            rd_data_i,
  output i2cms_pkg::out_item_t  result_o,
  output i2cms_pkg::buf_wr_t    wr_o,
  output logic [7:0]            rd_idx_o
);

  localparam logic [8:0] DEPTH9 = 9'(BUFFER_DEPTH);

  i2cms_pkg::mode_e mode_q, mode_d;
  i2cms_pkg::res_e  err_q, err_d;
  logic [7:0]       addr_rw_q, addr_rw_d;
  logic             stop_q, stop_d;
  logic             rsp_q, rsp_d;
  logic [7:0]       idx_q, idx_d;
  logic [7:0]       limit_q, limit_d;

  i2cms_pkg::act_e  act;
  i2cms_pkg::res_e  res;
  i2cms_pkg::res_e  fail_code;
  logic [7:0]       tx;
  logic             rxv;
  logic [7:0]       rxd;
  logic [7:0]       rxi;
  logic             done;
  logic             end_now;
  logic             fail_now;
  logic             is_rd;
  logic [7:0]       idx_inc;
  logic [8:0]       len9;
  logic [7:0]       new_addr;

  assign idx_inc  = idx_q + 8'd1;
  assign len9     = 9'(item_i.length);
  assign is_rd    = (i2cms_pkg::cmd_e'(item_i.cmd) == i2cms_pkg::CMD_READ);
  assign new_addr = {item_i.slave_address, is_rd};

  always_comb begin
    mode_d    = mode_q;
    err_d     = err_q;
    addr_rw_d = addr_rw_q;
    stop_d    = stop_q;
    rsp_d     = rsp_q;
    idx_d     = idx_q;
    limit_d   = limit_q;
    act       = i2cms_pkg::ACT_NONE;
    res       = i2cms_pkg::RES_OK;
    tx        = '0;
    rxv       = 1'b0;
    rxd       = '0;
    rxi       = '0;
    done      = 1'b0;
    end_now   = 1'b0;
    fail_now  = 1'b0;
    fail_code = i2cms_pkg::RES_OK;
    wr_o.en   = 1'b0;
    wr_o.idx  = item_i.load_index;
    wr_o.data = item_i.load_byte;

    if (fire_i) begin
      unique case (i2cms_pkg::cmd_e'(item_i.cmd))
        i2cms_pkg::CMD_LOAD: begin
          wr_o.en = 1'b1;
        end
        i2cms_pkg::CMD_WRITE, i2cms_pkg::CMD_READ: begin
          if (mode_q != i2cms_pkg::MODE_READY) begin
            res = i2cms_pkg::RES_NOT_READY;
          end else begin
            mode_d    = is_rd ? i2cms_pkg::MODE_READ : i2cms_pkg::MODE_WRITE;
            stop_d    = item_i.send_stop;
            err_d     = i2cms_pkg::RES_OK;
            idx_d     = '0;
            addr_rw_d = new_addr;
            if (is_rd) begin
              limit_d = (item_i.length == 8'd0) ? 8'd1 : item_i.length;
            end else begin
              limit_d = (len9 > DEPTH9) ? DEPTH9[7:0] : item_i.length;
            end
            if (rsp_q) begin
              rsp_d = 1'b0;
              act   = i2cms_pkg::ACT_ADDR;
              tx    = new_addr;
            end else begin
              act   = i2cms_pkg::ACT_START;
            end
          end
        end
        i2cms_pkg::CMD_EVENT: begin
          if (mode_q != i2cms_pkg::MODE_READY) begin
            unique case (item_i.bus_status[7:3])
              i2cms_pkg::ST_START, i2cms_pkg::ST_RSTART: begin
                act = i2cms_pkg::ACT_ADDR;
                tx  = addr_rw_q;
              end
              i2cms_pkg::ST_WADDR_ACK, i2cms_pkg::ST_WDATA_ACK: begin
                if ((idx_q < limit_q) && (9'(idx_q) < DEPTH9)) begin
                  act   = i2cms_pkg::ACT_SEND;
                  tx    = rd_data_i;
                  idx_d = idx_inc;
                end else begin
                  end_now = 1'b1;
                end
              end
              i2cms_pkg::ST_WADDR_NACK, i2cms_pkg::ST_RADDR_NACK: begin
                fail_now  = 1'b1;
                fail_code = i2cms_pkg::RES_ADDR_NACK;
              end
              i2cms_pkg::ST_WDATA_NACK: begin
                fail_now  = 1'b1;
                fail_code = i2cms_pkg::RES_DATA_NACK;
              end
              i2cms_pkg::ST_BUS_ERR: begin
                fail_now  = 1'b1;
                fail_code = i2cms_pkg::RES_BUS_ERR;
              end
              i2cms_pkg::ST_ARB_LOST: begin
                err_d  = i2cms_pkg::RES_ARB_LOST;
                act    = i2cms_pkg::ACT_RELEASE;
                mode_d = i2cms_pkg::MODE_READY;
                done   = 1'b1;
                res    = i2cms_pkg::RES_ARB_LOST;
              end
              i2cms_pkg::ST_RDATA_ACK: begin
                rxv   = 1'b1;
                rxd   = item_i.rx_byte;
                rxi   = idx_q;
                idx_d = idx_inc;
                // NACK the byte that will be the last one of the read.
                act   = ((9'(idx_inc) + 9'd1) < 9'(limit_q)) ?
                        i2cms_pkg::ACT_ACK : i2cms_pkg::ACT_NACK;
              end
              i2cms_pkg::ST_RADDR_ACK: begin
                act = ((9'(idx_q) + 9'd1) < 9'(limit_q)) ?
                      i2cms_pkg::ACT_ACK : i2cms_pkg::ACT_NACK;
              end
              i2cms_pkg::ST_RDATA_NACK: begin
                rxv     = 1'b1;
                rxd     = item_i.rx_byte;
                rxi     = idx_q;
                idx_d   = idx_inc;
                end_now = 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
        end
      endcase

      if (fail_now) begin
        err_d  = fail_code;
        act    = i2cms_pkg::ACT_STOP;
        mode_d = i2cms_pkg::MODE_READY;
        done   = 1'b1;
        res    = fail_code;
      end

      if (end_now) begin
        mode_d = i2cms_pkg::MODE_READY;
        done   = 1'b1;
        res    = err_q;
        if (stop_q) begin
          act = i2cms_pkg::ACT_STOP;
        end else begin
          act   = i2cms_pkg::ACT_RSTART;
          rsp_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= i2cms_pkg::MODE_READY;
      err_q     <= i2cms_pkg::RES_OK;
      addr_rw_q <= '0;
      stop_q    <= 1'b0;
      rsp_q     <= 1'b0;
      idx_q     <= '0;
      limit_q   <= '0;
    end else begin
      mode_q    <= mode_d;
      err_q     <= err_d;
      addr_rw_q <= addr_rw_d;
      stop_q    <= stop_d;
      rsp_q     <= rsp_d;
      idx_q     <= idx_d;
      limit_q   <= limit_d;
    end
  end

  assign rd_idx_o = idx_d;

  assign result_o.bus_action  = act;
  assign result_o.tx_byte     = tx;
  assign result_o.rx_valid    = rxv;
  assign result_o.rx_data     = rxd;
  assign result_o.rx_index    = rxi;
  assign result_o.done_res    = done;
  assign result_o.result_code = res;
  assign result_o.busy_res    = (mode_d != i2cms_pkg::MODE_READY);

endmodule

// ===== hw/rtl/i2c_master_transaction_sequencer.sv =====
// I2C master transaction sequencer: usage notes
//
// Input channel (in_valid_i, in_stall_o, in_item_i) carries buffer loads,
// write and read start commands, and bus status events from the byte-level
// bus interface. Output channel (out_valid_o, out_stall_i, out_item_o) returns
// one result per input transaction: the next bus action, the byte to send,
// any received byte with its index, and a done flag with the result code.
// An accepted transaction passes through the input register, then the
// result register, and a stall on the output can hold it in between.
// Throughput: one transaction per cycle while the output is not stalled; the
// decision is a single pass of logic on the registered state, and the next
// buffer byte is prefetched from the buffer memory every cycle so a send
// never waits on the read port. A stalled output holds its result while one
// more transaction waits in the input register; beyond that in_stall_o rises.
// Reset clears the mode to ready, the flags, the index and the error latch;
// the buffer contents are undefined until loaded.
module i2c_master_transaction_sequencer #(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  i2cms_pkg::in_item_t   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output i2cms_pkg::out_item_t  out_item_o
);

  logic                  in_vld_q;
  i2cms_pkg::in_item_t   in_item_q;
  logic                  out_vld_q;
  i2cms_pkg::out_item_t  out_item_q;
  logic                  advance;
  i2cms_pkg::out_item_t  result;
  i2cms_pkg::buf_wr_t    buf_wr;
  logic [7:0]            rd_idx;
  logic [7:0]            rd_data;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  i2cms_ctrl #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (advance),
    .item_i    (in_item_q),
    .rd_data_i (rd_data),
    .result_o  (result),
    .wr_o      (buf_wr),
    .rd_idx_o  (rd_idx)
  );

  i2cms_buf #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_buf (
    .clk_i     (clk_i),
    .wr_i      (buf_wr),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== hw/rtl/i2cms_checker.sv =====
// Port-level assertions for the I2C master transaction sequencer and their bind.
module i2cms_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input i2cms_pkg::out_item_t  out_item_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.done_res |-> !out_item_o.busy_res)
    else $error("done reported while still busy");

  a_rx_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.rx_valid |->
      (out_item_o.bus_action == i2cms_pkg::ACT_ACK) ||
      (out_item_o.bus_action == i2cms_pkg::ACT_NACK) ||
      (out_item_o.bus_action == i2cms_pkg::ACT_STOP) ||
      (out_item_o.bus_action == i2cms_pkg::ACT_RSTART))
    else $error("received byte without ack, nack or end");

  a_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.done_res &&
      (out_item_o.result_code == i2cms_pkg::RES_NOT_READY) |->
      (out_item_o.bus_action == i2cms_pkg::ACT_NONE) && out_item_o.busy_res)
    else $error("refused start changed the bus");

  a_tx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.tx_byte != 8'd0) |->
      (out_item_o.bus_action == i2cms_pkg::ACT_SEND) ||
      (out_item_o.bus_action == i2cms_pkg::ACT_ADDR))
    else $error("transmit byte set without a send");

endmodule

bind i2c_master_transaction_sequencer i2cms_checker u_i2cms_checker (.*);
